@@ hw/rtl/jac_pkg.sv @@
// shared widths, register indexes, reset values and types of the joystick axis conditioner
package jac_pkg;

    // field and state widths
    localparam int RAW_W  = 12;
    localparam int ACC_W  = 20;
    localparam int ANG_W  = 16;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;

    // serial multiplier: signed multiplicand, unsigned multiplier, signed product
    localparam int MC_W   = 17;
    localparam int MP_W   = 9;
    localparam int PROD_W = 26;

    // serial divider: unsigned dividend and divisor
    localparam int DVD_W  = 27;
    localparam int DVS_W  = 12;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_CENTER   = 3'd0;
    localparam logic [IDX_W-1:0] REG_SCALE    = 3'd1;
    localparam logic [IDX_W-1:0] REG_ALPHA    = 3'd2;
    localparam logic [IDX_W-1:0] REG_DZ_ENTER = 3'd3;
    localparam logic [IDX_W-1:0] REG_DZ_EXIT  = 3'd4;
    localparam logic [IDX_W-1:0] REG_NOISE    = 3'd5;

    // configuration reset values
    localparam logic [11:0] CENTER_RST   = 12'd2048;
    localparam logic [6:0]  SCALE_RST    = 7'd100;
    localparam logic [8:0]  ALPHA_RST    = 9'd26;
    localparam logic [14:0] DZ_ENTER_RST = 15'd1280;
    localparam logic [14:0] DZ_EXIT_RST  = 15'd1536;
    localparam logic [15:0] NOISE_RST    = 16'd512;

    // unity weight in q1.8
    localparam logic [8:0]  ALPHA_ONE    = 9'd256;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_AVG,
        ST_SCALE,
        ST_MAP,
        ST_FILT_NEW,
        ST_FILT_OLD,
        ST_FINISH,
        ST_EMIT
    } st_t;

    typedef enum logic [1:0] {
        MOP_SCALE,
        MOP_NEW,
        MOP_OLD
    } mop_t;

    typedef struct packed {
        logic start;
        logic clear;
    } mul_ctl_t;

endpackage

@@ hw/rtl/joystick_axis_conditioner.sv @@
// top level of the joystick axis conditioner: frame sums, sequencer and axis arithmetic
// words that do not close a frame give no result and, while the sequencer is idle,
// are taken one per cycle; the word that closes a frame starts the sequencer, which
// works x then y on the 27-bit serial divider and the 9-bit serial multiplier and
// then loads the output register
// reset clears sums, count, axis results and handshakes and loads register defaults
module joystick_axis_conditioner
    import jac_pkg::*;
#(
    parameter int AVG_COUNT = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration write port
    input  logic                    cfg_we,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    // sample input channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [RAW_W-1:0]        x_raw,
    input  logic [RAW_W-1:0]        y_raw,
    // result output channel
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    base_event,
    output logic                    tilt_event,
    output logic signed [ANG_W-1:0] base_angle,
    output logic signed [ANG_W-1:0] tilt_angle
);

    // sample counter holds 0 .. AVG_COUNT-1
    localparam int CNT_W = $clog2(AVG_COUNT + 1);

    // sequencer strobes for the datapath
    typedef struct packed {
        logic div_start;
        logic div_map;     // 0: sum over sample count, 1: scaled offset over centre
        logic sign_load;
        logic finish;
        logic emit;
        mop_t mop;
    } ctl_t;

    // configuration registers
    logic [11:0] center_reg;
    logic [6:0]  scale_reg;
    logic [8:0]  alpha_reg;
    logic [14:0] dz_enter_reg;
    logic [14:0] dz_exit_reg;
    logic [15:0] noise_reg;

    // frame state
    st_t                     state_reg, state_next;
    logic [ACC_W-1:0]        x_acc_reg, x_acc_next;
    logic [ACC_W-1:0]        y_acc_reg, y_acc_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    axis_reg, axis_next;
    logic                    neg_reg, neg_next;
    logic signed [ANG_W-1:0] x_out_reg, x_out_next;
    logic signed [ANG_W-1:0] y_out_reg, y_out_next;
    logic                    x_ev_reg, x_ev_next;
    logic                    y_ev_reg, y_ev_next;

    // output word register
    logic                    out_valid_reg, out_valid_next;
    logic                    base_event_reg, base_event_next;
    logic                    tilt_event_reg, tilt_event_next;
    logic signed [ANG_W-1:0] base_angle_reg, base_angle_next;
    logic signed [ANG_W-1:0] tilt_angle_reg, tilt_angle_next;

    // handshake and sequencer
    logic             in_acc;
    logic [CNT_W-1:0] cnt_inc;
    logic             frame_end;
    ctl_t             ctl;
    mul_ctl_t         mul_ctl;

    // shared serial units
    logic                     div_done;
    logic [DVD_W-1:0]         div_dvd;
    logic [DVS_W-1:0]         div_dvs;
    logic [DVD_W-1:0]         div_q;
    logic                     mul_done;
    logic signed [MC_W-1:0]   mul_mc;
    logic [MP_W-1:0]          mul_mp;
    logic signed [PROD_W-1:0] mul_p;

    // axis arithmetic
    logic [ACC_W-1:0]        acc_sel;
    logic signed [ANG_W-1:0] prev_sel;
    logic [8:0]              alpha_sat;
    logic [12:0]             ofs;
    logic [12:0]             ofs_neg;
    logic [11:0]             ofs_mag;
    logic [14:0]             lim;
    logic [14:0]             map_mag;
    logic signed [ANG_W-1:0] mapped;
    logic signed [PROD_W-1:0] sum_adj;
    logic signed [ANG_W-1:0] filt;
    logic signed [16:0]      filt_ext;
    logic signed [16:0]      prev_ext;
    logic [16:0]             filt_mag;
    logic [16:0]             prev_mag;
    logic                    dz_hit;
    logic signed [ANG_W-1:0] res;
    logic signed [17:0]      res_ext;
    logic signed [17:0]      prv_ext;
    logic signed [17:0]      thr_ext;
    logic signed [17:0]      d_up;
    logic signed [17:0]      d_dn;
    logic                    ev;

    // ---------------- configuration ----------------

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg   <= CENTER_RST;
            scale_reg    <= SCALE_RST;
            alpha_reg    <= ALPHA_RST;
            dz_enter_reg <= DZ_ENTER_RST;
            dz_exit_reg  <= DZ_EXIT_RST;
            noise_reg    <= NOISE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CENTER:   center_reg   <= cfg_data[11:0];
                REG_SCALE:    scale_reg    <= cfg_data[6:0];
                REG_ALPHA:    alpha_reg    <= cfg_data[8:0];
                REG_DZ_ENTER: dz_enter_reg <= cfg_data[14:0];
                REG_DZ_EXIT:  dz_exit_reg  <= cfg_data[14:0];
                REG_NOISE:    noise_reg    <= cfg_data;
                default:      ; // unused index, write dropped
            endcase
        end
    end

    // ---------------- input side ----------------

    // samples are taken only while the sequencer is parked
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign frame_end = (cnt_inc == CNT_W'(AVG_COUNT));

    // ---------------- sequencer ----------------

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && frame_end)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:    state_next = ST_AVG;
            ST_AVG:      if (div_done) state_next = ST_SCALE;
            ST_SCALE:    if (mul_done) state_next = ST_MAP;
            ST_MAP:      if (div_done) state_next = ST_FILT_NEW;
            ST_FILT_NEW: if (mul_done) state_next = ST_FILT_OLD;
            ST_FILT_OLD: if (mul_done) state_next = ST_FINISH;
            ST_FINISH:   state_next = axis_reg ? ST_EMIT : ST_START;
            ST_EMIT:     if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl           = '0;
        ctl.mop       = MOP_SCALE;
        mul_ctl       = '0;
        unique case (state_reg)
            ST_START:
            begin
                // average: frame sum over the sample count
                ctl.div_start = 1'b1;
            end
            ST_AVG:
            begin
                if (div_done)
                begin
                    // offset magnitude times scale
                    ctl.sign_load = 1'b1;
                    mul_ctl.start = 1'b1;
                    mul_ctl.clear = 1'b1;
                    ctl.mop       = MOP_SCALE;
                end
            end
            ST_SCALE:
            begin
                if (mul_done)
                begin
                    ctl.div_start = 1'b1;
                    ctl.div_map   = 1'b1;
                end
            end
            ST_MAP:
            begin
                if (div_done)
                begin
                    // alpha times the new mapped value
                    mul_ctl.start = 1'b1;
                    mul_ctl.clear = 1'b1;
                    ctl.mop       = MOP_NEW;
                end
            end
            ST_FILT_NEW:
            begin
                if (mul_done)
                begin
                    // add (1 - alpha) times the previous output
                    mul_ctl.start = 1'b1;
                    ctl.mop       = MOP_OLD;
                end
            end
            ST_FINISH:   ctl.finish = 1'b1;
            ST_EMIT:     ctl.emit   = !out_valid_reg || !out_stall;
            default:     ;
        endcase
    end

    // ---------------- shared units ----------------

    assign acc_sel  = axis_reg ? y_acc_reg : x_acc_reg;
    assign prev_sel = axis_reg ? y_out_reg : x_out_reg;

    always_comb
    begin
        if (ctl.div_map)
        begin
            // scaled offset in q.8, centre of zero divides by one
            div_dvd = {mul_p[DVD_W-9:0], 8'h00};
            div_dvs = (center_reg == 12'd0) ? DVS_W'(1) : center_reg;
        end
        else
        begin
            div_dvd = DVD_W'(acc_sel);
            div_dvs = DVS_W'(AVG_COUNT);
        end
    end

    // alpha above one saturates
    assign alpha_sat = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;

    always_comb
    begin
        unique case (ctl.mop)
            MOP_SCALE:
            begin
                mul_mc = MC_W'({1'b0, ofs_mag});
                mul_mp = MP_W'(scale_reg);
            end
            MOP_NEW:
            begin
                mul_mc = MC_W'(mapped);
                mul_mp = alpha_sat;
            end
            MOP_OLD:
            begin
                mul_mc = MC_W'(prev_sel);
                mul_mp = ALPHA_ONE - alpha_sat;
            end
            default:
            begin
                mul_mc = '0;
                mul_mp = '0;
            end
        endcase
    end

    jac_ser_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    jac_ser_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mul_ctl),
        .mcand  (mul_mc),
        .mplier (mul_mp),
        .done   (mul_done),
        .prod   (mul_p)
    );

    // ---------------- axis arithmetic ----------------

    // offset of the average from centre, as sign and magnitude
    assign ofs     = {1'b0, div_q[11:0]} - {1'b0, center_reg};
    assign ofs_neg = 13'd0 - ofs;
    assign ofs_mag = ofs[12] ? ofs_neg[11:0] : ofs[11:0];

    // clamp the scaled magnitude to scale_reg whole units
    assign lim     = {scale_reg, 8'h00};
    assign map_mag = (div_q > DVD_W'(lim)) ? lim : div_q[14:0];
    assign mapped  = neg_reg ? -$signed({1'b0, map_mag}) : $signed({1'b0, map_mag});

    // divide the weighted sum by 256, truncating toward zero
    assign sum_adj = mul_p + (mul_p[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
    assign filt    = sum_adj[23:8];

    // dead zone with hysteresis on the previous output
    assign filt_ext = 17'(filt);
    assign prev_ext = 17'(prev_sel);
    assign filt_mag = filt_ext[16] ? 17'(-filt_ext) : filt_ext;
    assign prev_mag = prev_ext[16] ? 17'(-prev_ext) : prev_ext;
    assign dz_hit   = (filt_mag < {2'b00, dz_enter_reg}) && (prev_mag < {2'b00, dz_exit_reg});
    assign res      = dz_hit ? '0 : filt;

    // event when the output moves further from zero by more than the threshold
    assign res_ext = 18'(res);
    assign prv_ext = 18'(prev_sel);
    assign thr_ext = $signed({2'b00, noise_reg});
    assign d_up    = res_ext - prv_ext;
    assign d_dn    = prv_ext - res_ext;
    assign ev      = (!res[ANG_W-1] && (res != '0) && (d_up > thr_ext)) ||
                     (res[ANG_W-1] && (d_dn > thr_ext));

    // ---------------- state update ----------------

    always_comb
    begin
        x_acc_next      = x_acc_reg;
        y_acc_next      = y_acc_reg;
        cnt_next        = cnt_reg;
        axis_next       = axis_reg;
        neg_next        = neg_reg;
        x_out_next      = x_out_reg;
        y_out_next      = y_out_reg;
        x_ev_next       = x_ev_reg;
        y_ev_next       = y_ev_reg;
        out_valid_next  = out_valid_reg && out_stall;
        base_event_next = base_event_reg;
        tilt_event_next = tilt_event_reg;
        base_angle_next = base_angle_reg;
        tilt_angle_next = tilt_angle_reg;

        if (in_acc)
        begin
            x_acc_next = x_acc_reg + ACC_W'(x_raw);
            y_acc_next = y_acc_reg + ACC_W'(y_raw);
            cnt_next   = frame_end ? '0 : cnt_inc;
        end

        if (ctl.sign_load)
        begin
            neg_next = ofs[12];
        end

        if (ctl.finish)
        begin
            if (axis_reg)
            begin
                y_out_next = res;
                y_ev_next  = ev;
            end
            else
            begin
                x_out_next = res;
                x_ev_next  = ev;
            end
            axis_next = !axis_reg;
        end

        if (ctl.emit)
        begin
            out_valid_next  = 1'b1;
            base_event_next = x_ev_reg;
            tilt_event_next = y_ev_reg;
            base_angle_next = x_out_reg;
            tilt_angle_next = y_out_reg;
            x_acc_next      = '0;
            y_acc_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            x_acc_reg     <= '0;
            y_acc_reg     <= '0;
            cnt_reg       <= '0;
            axis_reg      <= 1'b0;
            x_out_reg     <= '0;
            y_out_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            x_acc_reg     <= x_acc_next;
            y_acc_reg     <= y_acc_next;
            cnt_reg       <= cnt_next;
            axis_reg      <= axis_next;
            x_out_reg     <= x_out_next;
            y_out_reg     <= y_out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg        <= neg_next;
        x_ev_reg       <= x_ev_next;
        y_ev_reg       <= y_ev_next;
        base_event_reg <= base_event_next;
        tilt_event_reg <= tilt_event_next;
        base_angle_reg <= base_angle_next;
        tilt_angle_reg <= tilt_angle_next;
    end

    assign out_valid  = out_valid_reg;
    assign base_event = base_event_reg;
    assign tilt_event = tilt_event_reg;
    assign base_angle = base_angle_reg;
    assign tilt_angle = tilt_angle_reg;

endmodule

@@ hw/rtl/jac_ser_mul.sv @@
// shift-add multiplier, one multiplier bit per cycle, optional accumulate
module jac_ser_mul
    import jac_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mul_ctl_t                 ctl,
    input  logic signed [MC_W-1:0]   mcand,
    input  logic [MP_W-1:0]          mplier,
    output logic                     done,
    output logic signed [PROD_W-1:0] prod
);

    localparam int CNT_W = $clog2(MP_W);

    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic signed [PROD_W-1:0] mc_reg, mc_next;
    logic [MP_W-1:0]          mp_reg, mp_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            mc_next   = PROD_W'(mcand);
            mp_next   = mplier;
            cnt_next  = '0;
            busy_next = 1'b1;
            if (ctl.clear)
            begin
                acc_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (mp_reg[0])
            begin
                acc_next = acc_reg + mc_reg;
            end
            mc_next  = mc_reg <<< 1;
            mp_next  = mp_reg >> 1;
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(MP_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

@@ hw/rtl/jac_ser_div.sv @@
// restoring divider, one quotient bit per cycle
module jac_ser_div
    import jac_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic [DVD_W-1:0] q_reg, q_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   shifted;
    logic [DVS_W+1:0] trial;

    assign shifted = {rem_reg, q_reg[DVD_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DVS_W+1])
            begin
                rem_next = trial[DVS_W-1:0];
                q_next   = {q_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DVS_W-1:0];
                q_next   = {q_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
